@@ hdl/sliding_log_event_rate_limiter_macros.svh @@
// ---------------------------------------------------------------------------
// Sliding-log event rate limiter assertion macros
// Concurrent assertion shorthands used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef SLIDING_LOG_EVENT_RATE_LIMITER_MACROS_SVH
`define SLIDING_LOG_EVENT_RATE_LIMITER_MACROS_SVH

// same-cycle implication
`define SLERL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SLERL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/slerl_pkg.sv @@
// ---------------------------------------------------------------------------
// Sliding-log event rate limiter package
// Shared constants, codes and the decision record type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slerl_pkg;

  localparam int RING_DEPTH_DEF = 16;

  localparam int STAMP_W  = 32;
  localparam int HOLD_W   = 24;
  localparam int LIMIT_W  = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 24;

  localparam logic [CFG_IDX_W-1:0] REG_EVENT_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_FRAMES = 2'd1;

  localparam logic [1:0] VERDICT_ACCEPT  = 2'd0;
  localparam logic [1:0] VERDICT_LOCKED  = 2'd1;
  localparam logic [1:0] VERDICT_TRIPPED = 2'd2;

  typedef struct packed {
    logic               store;
    logic               trip;
    logic [1:0]         verdict;
    logic [HOLD_W-1:0]  remaining;
    logic [STAMP_W-1:0] lock_next;
  } dec_t;

endpackage

`default_nettype wire

@@ hdl/slerl_ram.sv @@
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one enabled read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slerl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/slerl_decide.sv @@
// ---------------------------------------------------------------------------
// Rate limiter decision
// Window check, lockout check and lockout update for one event.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slerl_decide (
  input  wire logic [slerl_pkg::STAMP_W-1:0] now,
  input  wire logic [slerl_pkg::STAMP_W-1:0] lock_until,
  input  wire logic [slerl_pkg::HOLD_W-1:0]  hold,
  input  wire logic                          lim_nz,
  input  wire logic [slerl_pkg::STAMP_W-1:0] old_stamp,
  output      slerl_pkg::dec_t               dec
);

  logic                            locked;
  logic                            recent;
  logic [slerl_pkg::STAMP_W-1:0]   age;
  logic [slerl_pkg::STAMP_W:0]     sum;
  logic [slerl_pkg::STAMP_W-1:0]   lock_trip;
  logic [slerl_pkg::STAMP_W-1:0]   left;
  logic [slerl_pkg::STAMP_W-1:0]   head_room;
  logic [slerl_pkg::HOLD_W-1:0]    left_sat;
  logic [slerl_pkg::HOLD_W-1:0]    room_sat;

  always_comb begin
    locked    = now < lock_until;
    age       = now - old_stamp;
    recent    = (old_stamp != '0) &&
                ((now < old_stamp) || (age < slerl_pkg::STAMP_W'(hold)));
    sum       = {1'b0, now} + (slerl_pkg::STAMP_W + 1)'(hold);
    lock_trip = sum[slerl_pkg::STAMP_W] ? '1 : sum[slerl_pkg::STAMP_W-1:0];
    left      = lock_until - now;
    head_room = ~now;
    left_sat  = (|left[slerl_pkg::STAMP_W-1:slerl_pkg::HOLD_W]) ?
                '1 : left[slerl_pkg::HOLD_W-1:0];
    room_sat  = (|head_room[slerl_pkg::STAMP_W-1:slerl_pkg::HOLD_W]) ?
                '1 : head_room[slerl_pkg::HOLD_W-1:0];

    dec.trip  = lim_nz && !locked && recent;
    dec.store = lim_nz && !locked && !recent;

    if (!lim_nz) begin
      dec.verdict = slerl_pkg::VERDICT_ACCEPT;
    end else if (locked) begin
      dec.verdict = slerl_pkg::VERDICT_LOCKED;
    end else if (recent) begin
      dec.verdict = slerl_pkg::VERDICT_TRIPPED;
    end else begin
      dec.verdict = slerl_pkg::VERDICT_ACCEPT;
    end

    // saturated lockout ends at all-ones
    if (dec.trip) begin
      dec.remaining = sum[slerl_pkg::STAMP_W] ? room_sat : hold;
      dec.lock_next = lock_trip;
    end else begin
      dec.remaining = locked ? left_sat : '0;
      dec.lock_next = lock_until;
    end
  end

endmodule

`default_nettype wire

@@ hdl/sliding_log_event_rate_limiter.sv @@
// Pipeline: an accepted beat is held in the input reg, its verdict in the result reg.
// Throughput: one beat per cycle absent back-pressure; the stamp ring read is issued
//   at accept, and the previous beat's stamp is forwarded when the addresses match.
// Reset: clears ring slot flags, head, lockout, registers and both stages at once;
//   no clearing pass, so the block accepts beats the cycle after reset.
// ---------------------------------------------------------------------------
// Sliding-log event rate limiter
// Refuses event beats that exceed a count within a frame window, with lockout.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sliding_log_event_rate_limiter_macros.svh"

module sliding_log_event_rate_limiter #(
  parameter int RING_DEPTH = slerl_pkg::RING_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [slerl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [slerl_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire logic [slerl_pkg::STAMP_W-1:0]   now_frame,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic [1:0]                      verdict,
  output      logic [slerl_pkg::HOLD_W-1:0]    lock_remaining
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int LIM_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = PTR_W + 2;

  logic [slerl_pkg::LIMIT_W-1:0] event_limit;
  logic [slerl_pkg::HOLD_W-1:0]  hold_frames;

  logic [PTR_W-1:0]              head;
  logic [slerl_pkg::STAMP_W-1:0] lock_until;
  logic [RING_DEPTH-1:0]         slot_full;

  logic                          s1_valid;
  logic [slerl_pkg::STAMP_W-1:0] s1_now;
  logic                          s1_byp;
  logic [slerl_pkg::STAMP_W-1:0] s1_byp_data;
  logic                          s1_full;

  logic [slerl_pkg::STAMP_W-1:0] ram_q;
  logic [slerl_pkg::STAMP_W-1:0] old_stamp;
  slerl_pkg::dec_t               dec;

  logic             s1_go;
  logic             in_fire;
  logic             wr_en;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] head_next;
  logic [LIM_W-1:0] lim;
  logic             lim_nz;
  logic [SUM_W-1:0] rd_sum;
  logic [PTR_W-1:0] rd_addr;

  always_comb begin
    lim    = (32'(event_limit) > 32'(RING_DEPTH)) ? LIM_W'(RING_DEPTH) : LIM_W'(event_limit);
    lim_nz = lim != '0;

    old_stamp = s1_byp ? s1_byp_data : (s1_full ? ram_q : '0);
  end

  always_comb begin
    s1_go    = s1_valid && (!out_valid || out_ready);
    in_ready = !rst && (!s1_valid || s1_go);
    in_fire  = in_valid && in_ready;

    head_inc  = (head == PTR_W'(RING_DEPTH - 1)) ? '0 : head + 1'b1;
    wr_en     = s1_go && dec.store;
    head_next = wr_en ? head_inc : head;

    // slot limit-1 places behind the head the next beat will see
    rd_sum  = SUM_W'(head_next) + SUM_W'(RING_DEPTH + 1) - SUM_W'(lim);
    rd_addr = (rd_sum >= SUM_W'(RING_DEPTH)) ?
              PTR_W'(rd_sum - SUM_W'(RING_DEPTH)) : PTR_W'(rd_sum);
  end

  slerl_ram #(
    .WIDTH (slerl_pkg::STAMP_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (wr_en),
    .waddr (head_inc),
    .wdata (s1_now),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  slerl_decide u_decide (
    .now        (s1_now),
    .lock_until (lock_until),
    .hold       (hold_frames),
    .lim_nz     (lim_nz),
    .old_stamp  (old_stamp),
    .dec        (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      event_limit <= '0;
      hold_frames <= '0;
      head        <= '0;
      lock_until  <= '0;
      slot_full   <= '0;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          slerl_pkg::REG_EVENT_LIMIT: event_limit <= cfg_data[slerl_pkg::LIMIT_W-1:0];
          slerl_pkg::REG_HOLD_FRAMES: hold_frames <= cfg_data;
          default: ;
        endcase
      end
      if (s1_go) begin
        head       <= head_next;
        lock_until <= dec.lock_next;
      end
      if (wr_en) begin
        slot_full[head_inc] <= 1'b1;
      end
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_now      <= now_frame;
      s1_byp      <= wr_en && (head_inc == rd_addr);
      s1_byp_data <= s1_now;
      s1_full     <= slot_full[rd_addr];
    end
    if (s1_go) begin
      verdict        <= dec.verdict;
      lock_remaining <= dec.remaining;
    end
  end

  `SLERL_ASSERT_NEXT(a_locked_keeps_state, clk, rst,
    s1_go && (dec.verdict == slerl_pkg::VERDICT_LOCKED),
    (head == $past(head)) && (lock_until == $past(lock_until)),
    "locked beat changed limiter state")
  `SLERL_ASSERT_NEXT(a_trip_sets_lock, clk, rst,
    s1_go && dec.trip,
    lock_until >= $past(s1_now),
    "lockout set before event frame")
  `SLERL_ASSERT_NOW(a_stall_blocks_input, clk, rst,
    s1_valid && out_valid && !out_ready,
    !in_ready,
    "input taken while pipeline stalled")
  `SLERL_ASSERT_NOW(a_verdict_code, clk, rst,
    out_valid,
    verdict != 2'd3,
    "undefined verdict code")

endmodule

`default_nettype wire

@@ bench/tb_sliding_log_event_rate_limiter.sv @@
// ---------------------------------------------------------------------------
// Sliding-log event rate limiter testbench
// Each event beat is scored against a cycle-free model of the ring of stamps
// and the lockout, and the model's verdicts are matched in order against the
// result beats. Directed cases cover the corner cases. Random phases follow,
// with windowed traffic near the limit, noise and long holds, mostly under
// random idling; a directed case applies a long receiver hold-off first.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sliding_log_event_rate_limiter;

  localparam logic [slerl_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [slerl_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int STALL_LEN   = 150;
  localparam int LOG_W       = $clog2(slerl_pkg::RING_DEPTH_DEF);

  typedef struct packed {
    logic [1:0]                   verdict;
    logic [slerl_pkg::HOLD_W-1:0] remaining;
  } verdict_beat_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [slerl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [slerl_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [slerl_pkg::STAMP_W-1:0]   now_frame = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [1:0]                      verdict;
  logic [slerl_pkg::HOLD_W-1:0]    lock_remaining;

  // model state
  logic [slerl_pkg::STAMP_W-1:0] stamp_log [slerl_pkg::RING_DEPTH_DEF] = '{default: '0};
  int                            log_head = 0;
  logic [slerl_pkg::STAMP_W-1:0] lock_until = '0;
  logic [slerl_pkg::LIMIT_W-1:0] cfg_limit = '0;
  logic [slerl_pkg::HOLD_W-1:0]  cfg_hold = '0;

  verdict_beat_t                 expected_verdicts [$];
  int                            mismatch_count = 0;
  int                            beats_in = 0;
  int                            quiet_cycles = 0;
  int                            stall_left = 0;
  bit                            stall_request = 1'b0;
  bit                            idle_on = 1'b1;
  logic [slerl_pkg::STAMP_W-1:0] frame_clock = '0;

  sliding_log_event_rate_limiter u_top (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .now_frame,
    .out_valid, .out_ready, .verdict, .lock_remaining
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic verdict_beat_t limiter_decide(
      input logic [slerl_pkg::STAMP_W-1:0] frame);
    verdict_beat_t                 res;
    int                            lim;
    int                            slot;
    logic [slerl_pkg::STAMP_W-1:0] prior;
    logic [slerl_pkg::STAMP_W:0]   reach;
    logic [slerl_pkg::STAMP_W-1:0] left;
    lim = (cfg_limit > slerl_pkg::RING_DEPTH_DEF) ?
          slerl_pkg::RING_DEPTH_DEF : int'(cfg_limit);
    res.verdict = slerl_pkg::VERDICT_ACCEPT;
    if (lim != 0) begin
      if (frame < lock_until) begin
        res.verdict = slerl_pkg::VERDICT_LOCKED;
      end else begin
        slot = (log_head + slerl_pkg::RING_DEPTH_DEF + 1 - lim) % slerl_pkg::RING_DEPTH_DEF;
        prior = stamp_log[LOG_W'(slot)];
        // empty slot never counts; a future stamp always counts
        if (prior != '0 && (frame < prior || frame - prior < cfg_hold)) begin
          reach = {1'b0, frame} + cfg_hold;
          lock_until = reach[slerl_pkg::STAMP_W] ? '1 : reach[slerl_pkg::STAMP_W-1:0];
          res.verdict = slerl_pkg::VERDICT_TRIPPED;
        end else begin
          log_head = (log_head + 1) % slerl_pkg::RING_DEPTH_DEF;
          stamp_log[LOG_W'(log_head)] = frame;
        end
      end
    end
    if (frame >= lock_until) begin
      res.remaining = '0;
    end else begin
      left = lock_until - frame;
      res.remaining = (left > 32'h00FF_FFFF) ? '1 : left[slerl_pkg::HOLD_W-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("mismatch %s: got %0h expected %0h at %0t ns", what, got, want, $realtime);
  endtask

  // input beat monitor and activity counter
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_verdicts.push_back(limiter_decide(now_frame));
        beats_in++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    verdict_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("unexpected result beat", 32'(verdict), '0);
      end else begin
        want = expected_verdicts.pop_front();
        if (verdict !== want.verdict) begin
          report_mismatch("verdict", 32'(verdict), 32'(want.verdict));
        end
        if (lock_remaining !== want.remaining) begin
          report_mismatch("lock_remaining", 32'(lock_remaining), 32'(want.remaining));
        end
      end
    end
  end

  // receiver: random idling plus a long hold-off on request
  always @(negedge clk) begin
    if (stall_request) begin
      stall_request = 1'b0;
      stall_left = STALL_LEN;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_on && ($urandom_range(0, 99) < 9));
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  task automatic send_event(input logic [slerl_pkg::STAMP_W-1:0] frame);
    while (idle_on && ($urandom_range(0, 99) < 9)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    now_frame <= frame;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [slerl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [slerl_pkg::CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      slerl_pkg::REG_EVENT_LIMIT: cfg_limit = data[slerl_pkg::LIMIT_W-1:0];
      slerl_pkg::REG_HOLD_FRAMES: cfg_hold = data[slerl_pkg::HOLD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic traffic_phase(input int n_items);
    int                            kind;
    int                            lim_eff;
    int                            step_max;
    int                            r;
    int                            i;
    logic [slerl_pkg::STAMP_W-1:0] f;
    kind = $urandom_range(0, 9);
    wait_drained();
    if (kind == 0) begin
      write_reg(slerl_pkg::REG_EVENT_LIMIT,
                slerl_pkg::CFG_W'($urandom()) & 24'hFF_FFE0);
      write_reg(slerl_pkg::REG_HOLD_FRAMES, slerl_pkg::CFG_W'($urandom()));
    end else if (kind == 1 && frame_clock < 32'hC000_0000) begin
      write_reg(slerl_pkg::REG_EVENT_LIMIT, slerl_pkg::CFG_W'($urandom_range(1, 16)));
      write_reg(slerl_pkg::REG_HOLD_FRAMES,
                slerl_pkg::CFG_W'($urandom_range(24'h10_0000, 24'hFF_FFFF)));
      n_items = 20;
    end else begin
      if ($urandom_range(0, 4) == 0) begin
        write_reg(slerl_pkg::REG_EVENT_LIMIT, slerl_pkg::CFG_W'($urandom_range(17, 31)));
      end else begin
        write_reg(slerl_pkg::REG_EVENT_LIMIT, slerl_pkg::CFG_W'($urandom_range(1, 16)));
      end
      if ($urandom_range(0, 9) == 0) begin
        write_reg(slerl_pkg::REG_HOLD_FRAMES, '0);
      end else begin
        write_reg(slerl_pkg::REG_HOLD_FRAMES, slerl_pkg::CFG_W'($urandom_range(1, 64)));
      end
    end
    lim_eff = (cfg_limit == 0) ? 1 :
              (cfg_limit > slerl_pkg::RING_DEPTH_DEF) ?
              slerl_pkg::RING_DEPTH_DEF : int'(cfg_limit);
    // pace the stream around the allowed rate so the window trips often
    step_max = (int'(cfg_hold) * 2) / lim_eff + 1;
    if (step_max > 4096) step_max = 4096;
    for (i = 0; i < n_items; i++) begin
      if (kind == 0) begin
        f = $urandom();
      end else begin
        r = $urandom_range(0, 99);
        if (lock_until > frame_clock && r < 30) begin
          frame_clock = lock_until - 1 + $urandom_range(0, 2);
        end else begin
          frame_clock = frame_clock + $urandom_range(0, step_max);
        end
        f = frame_clock;
        if (r >= 94) f = frame_clock - $urandom_range(1, 8);
      end
      send_event(f);
    end
  endtask

  task automatic test_limit_zero();
    send_event('0);
    send_event('1);
    send_event(32'h5AA5_A55A);
  endtask

  task automatic test_stamp_zero();
    wait_drained();
    write_reg(slerl_pkg::REG_EVENT_LIMIT, 24'hFF_FFE1);
    write_reg(slerl_pkg::REG_HOLD_FRAMES, 24'd10);
    send_event(32'd0);
    send_event(32'd0);
    send_event(32'd5);
  endtask

  task automatic test_lockout();
    send_event(32'd7);
    send_event(32'd9);
    send_event(32'd17);
  endtask

  task automatic test_unknown_register();
    wait_drained();
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, '1);
    send_event(32'd40);
  endtask

  task automatic test_hold_zero();
    wait_drained();
    write_reg(slerl_pkg::REG_HOLD_FRAMES, '0);
    send_event(32'd50);
    send_event(32'd50);
    send_event(32'd49);
  endtask

  task automatic test_window();
    wait_drained();
    write_reg(slerl_pkg::REG_EVENT_LIMIT, 24'd2);
    write_reg(slerl_pkg::REG_HOLD_FRAMES, 24'd10);
    send_event(32'd100);
    send_event(32'd101);
    send_event(32'd102);
  endtask

  task automatic test_limit_zero_locked();
    wait_drained();
    write_reg(slerl_pkg::REG_EVENT_LIMIT, '0);
    send_event(32'd105);
  endtask

  task automatic test_clamp();
    wait_drained();
    write_reg(slerl_pkg::REG_EVENT_LIMIT, 24'd31);
    write_reg(slerl_pkg::REG_HOLD_FRAMES, 24'd5);
    send_event(32'd200);
    send_event(32'd201);
    wait_drained();
    write_reg(slerl_pkg::REG_EVENT_LIMIT, 24'd16);
    send_event(32'd202);
  endtask

  task automatic test_backpressure();
    int i;
    wait_drained();
    write_reg(slerl_pkg::REG_EVENT_LIMIT, 24'd4);
    write_reg(slerl_pkg::REG_HOLD_FRAMES, 24'd20);
    stall_request = 1'b1;
    for (i = 0; i < 60; i++) begin
      frame_clock = frame_clock + $urandom_range(0, 10);
      send_event(frame_clock);
    end
    wait_drained();
  endtask

  task automatic test_random_traffic(input int target);
    while (beats_in < target) traffic_phase($urandom_range(30, 80));
  endtask

  task automatic test_back_to_back();
    int target;
    target = beats_in + 300;
    wait_drained();
    idle_on = 1'b0;
    while (beats_in < target) traffic_phase($urandom_range(30, 80));
    wait_drained();
    idle_on = 1'b1;
  endtask

  task automatic test_saturation();
    wait_drained();
    write_reg(slerl_pkg::REG_EVENT_LIMIT, 24'd1);
    write_reg(slerl_pkg::REG_HOLD_FRAMES, 24'hFF_FFFF);
    send_event(32'hFF00_0000);
    send_event(32'hFF00_0001);
    send_event(32'hF000_0000);
    wait_drained();
    write_reg(slerl_pkg::REG_EVENT_LIMIT, '0);
    send_event('0);
    wait_drained();
    write_reg(slerl_pkg::REG_EVENT_LIMIT, 24'd1);
    send_event('1);
    send_event('1);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_limit_zero();
    test_stamp_zero();
    test_lockout();
    test_unknown_register();
    test_hold_zero();
    test_window();
    test_limit_zero_locked();
    test_clamp();
    frame_clock = 32'd1000;
    test_backpressure();
    test_random_traffic(700);
    test_back_to_back();
    test_random_traffic(1600);
    test_saturation();
    wait_drained();
    repeat (4) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
